// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ctms_pkg.sv =====
// Package for the chunked tile map store: tile codes, register indexes,
// configuration and queue status types, back-end state type. No dependencies.
`default_nettype none

package ctms_pkg;

    // Tile codes
    localparam logic [2:0] TILE_EMPTY       = 3'd0;
    localparam logic [2:0] TILE_FLOOR       = 3'd1;
    localparam logic [2:0] TILE_STAIRS_UP   = 3'd2;
    localparam logic [2:0] TILE_STAIRS_DOWN = 3'd3;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_COUNT_X = 2'd0;
    localparam logic [1:0] REG_COUNT_Y = 2'd1;
    localparam logic [1:0] REG_COUNT_Z = 2'd2;

    // Reset values of the count registers
    localparam logic [2:0] RST_COUNT_X = 3'd4;
    localparam logic [2:0] RST_COUNT_Y = 3'd4;
    localparam logic [1:0] RST_COUNT_Z = 2'd2;

    typedef struct packed {
        logic [2:0] count_x;
        logic [2:0] count_y;
        logic [1:0] count_z;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [0:0] {
        BK_RUN,
        BK_FILL
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/ctms_fifo.sv =====
// Two-entry request queue between the front and back ends.
// Depends on ctms_pkg for the status struct.
`default_nettype none

module ctms_fifo #(
    parameter int W = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [W-1:0]         i_data,
    input  wire logic                 i_pop,
    output logic [W-1:0]              o_data,
    output ctms_pkg::t_fifo_stat      o_stat
);

    logic [W-1:0] r_slot [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_data;
    end

    assign o_data       = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

`default_nettype wire

// ===== rtl/ctms_front.sv =====
// Front end: configuration registers on the APB port, request accept,
// chunk key range check and address formation. Depends on ctms_pkg.
`default_nettype none

module ctms_front #(
    parameter int CHUNK_SHIFT  = 4,
    parameter int MAX_CHUNKS_X = 4,
    parameter int MAX_CHUNKS_Y = 4,
    parameter int MAX_CHUNKS_Z = 2,
    localparam int NCH = MAX_CHUNKS_X * MAX_CHUNKS_Y * MAX_CHUNKS_Z,
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1,
    localparam int OW  = 2 * CHUNK_SHIFT,
    localparam int EW  = 2 + CW + OW + 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // request
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_req_type,
    input  wire logic signed [31:0]    i_abs_x,
    input  wire logic signed [31:0]    i_abs_y,
    input  wire logic signed [31:0]    i_abs_z,
    input  wire logic [2:0]            i_tile_value,
    // queue side
    input  wire ctms_pkg::t_fifo_stat  i_fifo_stat,
    output logic                       o_push,
    output logic [EW-1:0]              o_entry
);

    localparam int XW = (MAX_CHUNKS_X > 1) ? $clog2(MAX_CHUNKS_X) : 1;
    localparam int YW = (MAX_CHUNKS_Y > 1) ? $clog2(MAX_CHUNKS_Y) : 1;
    localparam int ZW = (MAX_CHUNKS_Z > 1) ? $clog2(MAX_CHUNKS_Z) : 1;
    localparam int KW = 32 - CHUNK_SHIFT;

    ctms_pkg::t_cfg r_cfg;
    logic           wr_en;

    logic [KW-1:0]  kx;
    logic [KW-1:0]  ky;
    logic [31:0]    kz;
    logic [31:0]    lim_x;
    logic [31:0]    lim_y;
    logic [31:0]    lim_z;
    logic           oor;
    logic [CW-1:0]  chunk;
    logic [OW-1:0]  offset;

    // register write
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_x <= ctms_pkg::RST_COUNT_X;
            r_cfg.count_y <= ctms_pkg::RST_COUNT_Y;
            r_cfg.count_z <= ctms_pkg::RST_COUNT_Z;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                ctms_pkg::REG_COUNT_X: r_cfg.count_x <= pwdata[2:0];
                ctms_pkg::REG_COUNT_Y: r_cfg.count_y <= pwdata[2:0];
                ctms_pkg::REG_COUNT_Z: r_cfg.count_z <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            ctms_pkg::REG_COUNT_X: prdata = {29'd0, r_cfg.count_x};
            ctms_pkg::REG_COUNT_Y: prdata = {29'd0, r_cfg.count_y};
            ctms_pkg::REG_COUNT_Z: prdata = {30'd0, r_cfg.count_z};
            default: prdata = 32'd0;
        endcase
    end

    // chunk key and saturated limits; coordinates compare as unsigned
    always_comb begin
        kx = i_abs_x[31:CHUNK_SHIFT];
        ky = i_abs_y[31:CHUNK_SHIFT];
        kz = i_abs_z;
        lim_x = ({29'd0, r_cfg.count_x} > 32'(MAX_CHUNKS_X)) ?
                32'(MAX_CHUNKS_X) : {29'd0, r_cfg.count_x};
        lim_y = ({29'd0, r_cfg.count_y} > 32'(MAX_CHUNKS_Y)) ?
                32'(MAX_CHUNKS_Y) : {29'd0, r_cfg.count_y};
        lim_z = ({30'd0, r_cfg.count_z} > 32'(MAX_CHUNKS_Z)) ?
                32'(MAX_CHUNKS_Z) : {30'd0, r_cfg.count_z};
        oor = ({{CHUNK_SHIFT{1'b0}}, kx} >= lim_x) ||
              ({{CHUNK_SHIFT{1'b0}}, ky} >= lim_y) ||
              (kz >= lim_z);
    end

    // chunk number (z-major) and tile offset inside the chunk
    always_comb begin
        chunk = CW'(kz[ZW-1:0]) * CW'(MAX_CHUNKS_Y * MAX_CHUNKS_X)
              + CW'(ky[YW-1:0]) * CW'(MAX_CHUNKS_X)
              + CW'(kx[XW-1:0]);
        offset = {i_abs_y[CHUNK_SHIFT-1:0], i_abs_x[CHUNK_SHIFT-1:0]};
    end

    assign busy    = i_fifo_stat.full;
    assign o_push  = start && !busy;
    assign o_entry = {i_req_type, oor, chunk, offset, i_tile_value};

endmodule

`default_nettype wire

// ===== rtl/ctms_back.sv =====
// Back end: chunk valid bits, tile memory, chunk fill sequencer and result
// register. Depends on ctms_pkg.
`default_nettype none

module ctms_back #(
    parameter int CHUNK_SHIFT  = 4,
    parameter int MAX_CHUNKS_X = 4,
    parameter int MAX_CHUNKS_Y = 4,
    parameter int MAX_CHUNKS_Z = 2,
    localparam int NCH = MAX_CHUNKS_X * MAX_CHUNKS_Y * MAX_CHUNKS_Z,
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1,
    localparam int OW  = 2 * CHUNK_SHIFT,
    localparam int EW  = 2 + CW + OW + 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [EW-1:0]         i_entry,
    input  wire ctms_pkg::t_fifo_stat  i_fifo_stat,
    output logic                       o_pop,
    output logic                       o_done,
    output logic [2:0]                 o_tile_code,
    output logic                       o_walkable,
    output logic                       o_out_of_range
);

    localparam int AW    = CW + OW;
    localparam int DEPTH = NCH << OW;

    ctms_pkg::t_back_state r_state;
    ctms_pkg::t_back_state n_state;

    logic [2:0]     r_mem [DEPTH];
    logic [2:0]     r_rd_data;
    logic [NCH-1:0] r_chunk_valid;

    logic [OW-1:0]  r_fill_cnt;
    logic [CW-1:0]  r_fill_chunk;
    logic [OW-1:0]  r_fill_off;
    logic [2:0]     r_fill_val;

    logic           r_res_vld;
    logic           r_res_rd;
    logic           r_res_oor;

    // queue entry fields
    logic           e_wr;
    logic           e_oor;
    logic [CW-1:0]  e_chunk;
    logic [OW-1:0]  e_off;
    logic [2:0]     e_val;
    logic           e_alloc;

    // control from the sequencer
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [2:0]     mem_wdata;
    logic           set_res;
    logic           res_rd;
    logic           res_oor;
    logic           set_valid;
    logic           start_fill;

    logic [2:0]     code;

    assign {e_wr, e_oor, e_chunk, e_off, e_val} = i_entry;
    assign e_alloc = r_chunk_valid[e_chunk];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctms_pkg::BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and sequencer outputs
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = {e_chunk, e_off};
        mem_wdata  = e_val;
        set_res    = 1'b0;
        res_rd     = 1'b0;
        res_oor    = 1'b0;
        set_valid  = 1'b0;
        start_fill = 1'b0;
        unique case (r_state)
            ctms_pkg::BK_RUN: begin
                if (!i_fifo_stat.empty) begin
                    o_pop = 1'b1;
                    if (e_oor) begin
                        set_res = 1'b1;
                        res_oor = 1'b1;
                    end else if (e_wr && e_alloc) begin
                        mem_we  = 1'b1;
                        set_res = 1'b1;
                    end else if (e_wr) begin
                        // first write to the chunk: sweep it with floor
                        start_fill = 1'b1;
                        n_state    = ctms_pkg::BK_FILL;
                    end else begin
                        set_res = 1'b1;
                        res_rd  = e_alloc;
                    end
                end
            end
            ctms_pkg::BK_FILL: begin
                mem_we    = 1'b1;
                mem_addr  = {r_fill_chunk, r_fill_cnt};
                mem_wdata = (r_fill_cnt == r_fill_off) ? r_fill_val : ctms_pkg::TILE_FLOOR;
                if (r_fill_cnt == {OW{1'b1}}) begin
                    set_valid = 1'b1;
                    set_res   = 1'b1;
                    n_state   = ctms_pkg::BK_RUN;
                end
            end
            default: n_state = ctms_pkg::BK_RUN;
        endcase
    end

    // tile memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rd_data <= r_mem[mem_addr];
    end

    // fill sequencer registers
    always_ff @(posedge i_clk) begin
        if (start_fill) begin
            r_fill_chunk <= e_chunk;
            r_fill_off   <= e_off;
            r_fill_val   <= e_val;
            r_fill_cnt   <= '0;
        end else if (r_state == ctms_pkg::BK_FILL) begin
            r_fill_cnt <= r_fill_cnt + OW'(1);
        end
    end

    // chunk valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_valid <= '0;
        end else if (set_valid) begin
            r_chunk_valid[r_fill_chunk] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_oor <= 1'b0;
        end else begin
            r_res_vld <= set_res;
            r_res_rd  <= set_res && res_rd;
            r_res_oor <= set_res && res_oor;
        end
    end

    // result fields; zero outside the strobe cycle
    always_comb begin
        code = (r_res_vld && r_res_rd) ? r_rd_data : ctms_pkg::TILE_EMPTY;
        case (code) inside
            ctms_pkg::TILE_FLOOR, ctms_pkg::TILE_STAIRS_UP, ctms_pkg::TILE_STAIRS_DOWN:
                o_walkable = 1'b1;
            default:
                o_walkable = 1'b0;
        endcase
    end

    assign o_done         = r_res_vld;
    assign o_tile_code    = code;
    assign o_out_of_range = r_res_vld && r_res_oor;

endmodule

`default_nettype wire

// ===== rtl/chunked_tile_map_store_top.sv =====
// Top level of the chunked tile map store: front end, request queue, back end.
// Depends on ctms_pkg, ctms_front, ctms_fifo and ctms_back.
`default_nettype none

// Sparse tile map, split into chunks of 2^CHUNK_SHIFT x 2^CHUNK_SHIFT tiles.
// A request is taken when start is high and busy is low. One result per
// request comes back on o_done for a single cycle, in request order, and the
// receiver must take it then. With the back end free and the queue empty, a
// request goes through the queue slot and then the result register to o_done.
// Reads and writes to chunks already allocated go at one per cycle while no
// chunk fill holds the back end, set by the single port of the tile memory.
// The first write to a chunk holds the back end while that port sweeps the
// chunk with floor and the new value; the two-entry queue then fills and
// busy rises. Chunk valid bits are flip-flops cleared by reset, so there is
// no clearing pass and the block takes requests right after reset.
module chunked_tile_map_store_top #(
    parameter int CHUNK_SHIFT  = 4,
    parameter int MAX_CHUNKS_X = 4,
    parameter int MAX_CHUNKS_Y = 4,
    parameter int MAX_CHUNKS_Z = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // request
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_req_type,
    input  wire logic signed [31:0] i_abs_x,
    input  wire logic signed [31:0] i_abs_y,
    input  wire logic signed [31:0] i_abs_z,
    input  wire logic [2:0]         i_tile_value,
    // result
    output logic                    o_done,
    output logic [2:0]              o_tile_code,
    output logic                    o_walkable,
    output logic                    o_out_of_range
);

    localparam int NCH = MAX_CHUNKS_X * MAX_CHUNKS_Y * MAX_CHUNKS_Z;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int OW  = 2 * CHUNK_SHIFT;
    localparam int EW  = 2 + CW + OW + 3;

    ctms_pkg::t_fifo_stat fifo_stat;
    logic                 push;
    logic                 pop;
    logic [EW-1:0]        entry_in;
    logic [EW-1:0]        entry_out;

    ctms_front #(
        .CHUNK_SHIFT  (CHUNK_SHIFT),
        .MAX_CHUNKS_X (MAX_CHUNKS_X),
        .MAX_CHUNKS_Y (MAX_CHUNKS_Y),
        .MAX_CHUNKS_Z (MAX_CHUNKS_Z)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_abs_x      (i_abs_x),
        .i_abs_y      (i_abs_y),
        .i_abs_z      (i_abs_z),
        .i_tile_value (i_tile_value),
        .i_fifo_stat  (fifo_stat),
        .o_push       (push),
        .o_entry      (entry_in)
    );

    ctms_fifo #(
        .W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_stat  (fifo_stat)
    );

    ctms_back #(
        .CHUNK_SHIFT  (CHUNK_SHIFT),
        .MAX_CHUNKS_X (MAX_CHUNKS_X),
        .MAX_CHUNKS_Y (MAX_CHUNKS_Y),
        .MAX_CHUNKS_Z (MAX_CHUNKS_Z)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (entry_out),
        .i_fifo_stat    (fifo_stat),
        .o_pop          (pop),
        .o_done         (o_done),
        .o_tile_code    (o_tile_code),
        .o_walkable     (o_walkable),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

// ===== rtl/ctms_checker.sv =====
// Port-level checker for the chunked tile map store, bound to the top level.
// Depends on assert_macros.svh and ctms_pkg for the tile codes.
`default_nettype none

`include "assert_macros.svh"

module ctms_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [2:0] o_tile_code,
    input wire logic       o_walkable,
    input wire logic       o_out_of_range
);

    logic code_empty;
    logic code_walk;

    // tile code classes
    assign code_empty = (o_tile_code == ctms_pkg::TILE_EMPTY);
    assign code_walk  = (o_tile_code == ctms_pkg::TILE_FLOOR) ||
                        (o_tile_code == ctms_pkg::TILE_STAIRS_UP) ||
                        (o_tile_code == ctms_pkg::TILE_STAIRS_DOWN);

    // after reset the queue is empty and no result is pending
    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !busy && !o_done)

    // result fields are quiet between strobes
    `ASSERT_SAME(a_quiet, i_clk, i_rst_n, !o_done, code_empty && !o_walkable && !o_out_of_range)

    // an out-of-range request never returns tile data
    `ASSERT_SAME(a_oor_empty, i_clk, i_rst_n, o_out_of_range, code_empty && !o_walkable)

    // walkable only for floor or stairs
    `ASSERT_SAME(a_walk_code, i_clk, i_rst_n, o_walkable, code_walk)

endmodule

bind chunked_tile_map_store_top ctms_checker u_ctms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_done         (o_done),
    .o_tile_code    (o_tile_code),
    .o_walkable     (o_walkable),
    .o_out_of_range (o_out_of_range)
);

`default_nettype wire

// ===== tb/sv/chunked_tile_map_store_top_test.sv =====
// Self-checking testbench for chunked_tile_map_store_top: drives tile read and write
// requests and APB writes to the chunk count registers, and checks every result.
// Depends on ctms_pkg and the RTL of chunked_tile_map_store_top.
`default_nettype none

module chunked_tile_map_store_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK_SHIFT  = 4;
    localparam int MAX_CHUNKS_X = 4;
    localparam int MAX_CHUNKS_Y = 4;
    localparam int MAX_CHUNKS_Z = 2;

    localparam int NUM_CHUNKS  = MAX_CHUNKS_X * MAX_CHUNKS_Y * MAX_CHUNKS_Z;
    localparam int CHUNK_TILES = 1 << (2 * CHUNK_SHIFT);
    localparam int TOTAL_TILES = NUM_CHUNKS * CHUNK_TILES;
    localparam int FILL_CYCLES = CHUNK_TILES;
    localparam logic [31:0] REL_MASK = (32'd1 << CHUNK_SHIFT) - 32'd1;

    localparam bit REQ_READ  = 1'b0;
    localparam bit REQ_WRITE = 1'b1;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [2:0] tile_code;
        logic       walkable;
        logic       out_of_range;
    } t_tile_result;

    // Tile map predictor and in-order result checker
    class tile_map_scoreboard;
        int unsigned  count_x;
        int unsigned  count_y;
        int unsigned  count_z;
        bit           chunk_valid [NUM_CHUNKS];
        bit [2:0]     tile_mem [TOTAL_TILES];
        t_tile_result expected_results [$];
        int unsigned  fail_count;
        int unsigned  reads;
        int unsigned  writes;
        int unsigned  oor_hits;
        int unsigned  chunks_filled;

        function new();
            count_x = 32'(ctms_pkg::RST_COUNT_X);
            count_y = 32'(ctms_pkg::RST_COUNT_Y);
            count_z = 32'(ctms_pkg::RST_COUNT_Z);
            foreach (chunk_valid[i]) chunk_valid[i] = 1'b0;
            fail_count    = 0;
            reads         = 0;
            writes        = 0;
            oor_hits      = 0;
            chunks_filled = 0;
        endfunction

        function void set_count(logic [1:0] idx, logic [31:0] value);
            case (idx)
                ctms_pkg::REG_COUNT_X: count_x = 32'(value[2:0]);
                ctms_pkg::REG_COUNT_Y: count_y = 32'(value[2:0]);
                ctms_pkg::REG_COUNT_Z: count_z = 32'(value[1:0]);
                default: ;
            endcase
        endfunction

        // counts above the array size behave as the array size
        function int unsigned clamp_count(int unsigned cnt, int unsigned limit);
            return (cnt > limit) ? limit : cnt;
        endfunction

        // Work out the result of one accepted request and update the map
        function void note_request(bit is_wr, logic [31:0] ax, logic [31:0] ay,
                                   logic [31:0] az, logic [2:0] value);
            logic [31:0]  kx;
            logic [31:0]  ky;
            int unsigned  chunk;
            int unsigned  base;
            int unsigned  idx;
            t_tile_result res;
            kx  = ax >> CHUNK_SHIFT;
            ky  = ay >> CHUNK_SHIFT;
            res = '0;
            if (is_wr) writes++; else reads++;
            if (kx >= clamp_count(count_x, MAX_CHUNKS_X) ||
                ky >= clamp_count(count_y, MAX_CHUNKS_Y) ||
                az >= clamp_count(count_z, MAX_CHUNKS_Z)) begin
                res.out_of_range = 1'b1;
                oor_hits++;
            end else begin
                chunk = (az * MAX_CHUNKS_Y + ky) * MAX_CHUNKS_X + kx;
                base  = chunk * CHUNK_TILES;
                idx   = base + (((ay & REL_MASK) << CHUNK_SHIFT) | (ax & REL_MASK));
                if (is_wr) begin
                    // first write into a chunk lays floor over all of it
                    if (!chunk_valid[chunk]) begin
                        for (int i = 0; i < CHUNK_TILES; i++)
                            tile_mem[base + i] = ctms_pkg::TILE_FLOOR;
                        chunk_valid[chunk] = 1'b1;
                        chunks_filled++;
                    end
                    tile_mem[idx] = value;
                end else if (chunk_valid[chunk]) begin
                    res.tile_code = tile_mem[idx];
                end
            end
            res.walkable = !is_wr && (res.tile_code == ctms_pkg::TILE_FLOOR ||
                                      res.tile_code == ctms_pkg::TILE_STAIRS_UP ||
                                      res.tile_code == ctms_pkg::TILE_STAIRS_DOWN);
            expected_results.push_back(res);
        endfunction

        function void note_failure();
            fail_count++;
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_result(logic [2:0] code, logic walk, logic oor);
            t_tile_result exp_res;
            if (expected_results.size() == 0) begin
                note_failure();
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR %0t: unexpected result code %0d walk %0b oor %0b",
                             $realtime, code, walk, oor);
                return;
            end
            exp_res = expected_results.pop_front();
            if (code !== exp_res.tile_code || walk !== exp_res.walkable ||
                oor !== exp_res.out_of_range) begin
                note_failure();
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR %0t: code %0d/%0d walk %0b/%0b oor %0b/%0b (exp/act)",
                             $realtime, exp_res.tile_code, code, exp_res.walkable, walk,
                             exp_res.out_of_range, oor);
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void flag_leftovers();
            if (expected_results.size() != 0) begin
                note_failure();
                $display("ERROR: %0d results never arrived", expected_results.size());
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic               i_req_type;
    logic signed [31:0] i_abs_x;
    logic signed [31:0] i_abs_y;
    logic signed [31:0] i_abs_z;
    logic [2:0]         i_tile_value;
    logic               o_done;
    logic [2:0]         o_tile_code;
    logic               o_walkable;
    logic               o_out_of_range;

    tile_map_scoreboard board = new();

    logic [31:0] last_x;
    logic [31:0] last_y;
    logic [31:0] last_z;
    int unsigned settings_used;

    chunked_tile_map_store_top #(
        .CHUNK_SHIFT  (CHUNK_SHIFT),
        .MAX_CHUNKS_X (MAX_CHUNKS_X),
        .MAX_CHUNKS_Y (MAX_CHUNKS_Y),
        .MAX_CHUNKS_Z (MAX_CHUNKS_Z)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_abs_x        (i_abs_x),
        .i_abs_y        (i_abs_y),
        .i_abs_z        (i_abs_z),
        .i_tile_value   (i_tile_value),
        .o_done         (o_done),
        .o_tile_code    (o_tile_code),
        .o_walkable     (o_walkable),
        .o_out_of_range (o_out_of_range)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result(o_tile_code, o_walkable, o_out_of_range);
    end

    // Hold one request until the block takes it; called and left at a falling edge
    task automatic send_request(bit is_wr, logic [31:0] ax, logic [31:0] ay,
                                logic [31:0] az, logic [2:0] value);
        start        <= 1'b1;
        i_req_type   <= is_wr;
        i_abs_x      <= ax;
        i_abs_y      <= ay;
        i_abs_z      <= az;
        i_tile_value <= value;
        do @(posedge i_clk); while (busy);
        board.note_request(is_wr, ax, ay, az, value);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int unsigned n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Let every result come back and any chunk fill finish
    task automatic settle_block();
        start <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (FILL_CYCLES + 8) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_count(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_count(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Coordinate near the edge of the configured range, or negative
    function automatic logic [31:0] edge_coord(int unsigned cnt);
        case ($urandom_range(0, 3))
            0: return (cnt << CHUNK_SHIFT) - 32'd1;
            1: return cnt << CHUNK_SHIFT;
            2: return -$urandom_range(1, 32);
            default: return 32'h8000_0000 | $urandom;
        endcase
    endfunction

    // Mostly in-range traffic with revisits, plus wide noise and edge coordinates
    task automatic send_random_request(bit allow_idle);
        int unsigned pick;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            ax = last_x;
            ay = last_y;
            az = last_z;
        end else if (pick < 75) begin
            ax = $urandom_range(0, (MAX_CHUNKS_X << CHUNK_SHIFT) + 3);
            ay = $urandom_range(0, (MAX_CHUNKS_Y << CHUNK_SHIFT) + 3);
            az = $urandom_range(0, MAX_CHUNKS_Z);
            last_x = ax;
            last_y = ay;
            last_z = az;
        end else if (pick < 88) begin
            ax = $urandom;
            ay = $urandom;
            az = $urandom;
        end else begin
            ax = edge_coord(board.count_x);
            ay = edge_coord(board.count_y);
            az = ($urandom_range(0, 1)) ? edge_coord(board.count_z) : $urandom_range(0, 1);
        end
        send_request(1'($urandom_range(0, 1)), ax, ay, az, 3'($urandom_range(0, 7)));
        if (allow_idle && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 8));
    endtask

    // Main sequence
    initial begin
        int unsigned phase_x [NUM_PHASES] = '{4, 0, 7, 1, 4, 3, 5, 4};
        int unsigned phase_y [NUM_PHASES] = '{4, 4, 7, 2, 0, 3, 6, 4};
        int unsigned phase_z [NUM_PHASES] = '{2, 2, 3, 1, 2, 0, 3, 2};
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_req_type   = REQ_READ;
        i_abs_x      = '0;
        i_abs_y      = '0;
        i_abs_z      = '0;
        i_tile_value = ctms_pkg::TILE_EMPTY;
        last_x       = '0;
        last_y       = '0;
        last_z       = '0;
        settings_used = 1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: allocation, every tile code, range edges, negative coordinates
        send_request(REQ_READ,  0, 0, 0, 3'd7);           // chunk never allocated
        send_request(REQ_WRITE, 0, 0, 0, ctms_pkg::TILE_STAIRS_UP);  // fill then store
        send_request(REQ_READ,  0, 0, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_READ,  1, 0, 0, ctms_pkg::TILE_EMPTY);     // floor left by the fill
        send_request(REQ_WRITE, 15, 15, 0, 3'd7);
        send_request(REQ_READ,  15, 15, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_WRITE, 15, 15, 0, ctms_pkg::TILE_STAIRS_DOWN);
        send_request(REQ_READ,  15, 15, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_WRITE, 5, 5, 0, 3'd4);
        send_request(REQ_WRITE, 5, 6, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_WRITE, 6, 5, 0, 3'd5);
        send_request(REQ_WRITE, 6, 6, 0, 3'd6);
        send_request(REQ_READ,  5, 5, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_READ,  5, 6, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_READ,  6, 5, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_READ,  6, 6, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_WRITE, 63, 63, 1, ctms_pkg::TILE_FLOOR);   // last in-range tile
        send_request(REQ_READ,  63, 63, 1, ctms_pkg::TILE_EMPTY);
        send_request(REQ_READ,  64, 0, 0, ctms_pkg::TILE_EMPTY);    // x just past range
        send_request(REQ_WRITE, 0, 64, 0, ctms_pkg::TILE_STAIRS_UP); // dropped write
        send_request(REQ_WRITE, 0, 0, 2, ctms_pkg::TILE_STAIRS_UP);
        send_request(REQ_READ,  32'hFFFF_FFFF, 0, 0, ctms_pkg::TILE_EMPTY);
        send_request(REQ_WRITE, 0, 32'h8000_0000, 0, ctms_pkg::TILE_STAIRS_DOWN);
        send_request(REQ_READ,  0, 0, 32'hFFFF_FFFF, ctms_pkg::TILE_EMPTY);
        send_request(REQ_READ,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     ctms_pkg::TILE_EMPTY);

        // Random phases under several count settings; the last one runs without gaps
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_block();
            if (p != 0) begin
                write_count(ctms_pkg::REG_COUNT_X, phase_x[p]);
                write_count(ctms_pkg::REG_COUNT_Y, phase_y[p]);
                write_count(ctms_pkg::REG_COUNT_Z, phase_z[p]);
                settings_used++;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_request(p != NUM_PHASES - 1);
        end

        settle_block();
        board.flag_leftovers();
        $display("Covered %0d requests (%0d reads, %0d writes) over %0d count settings;",
                 board.reads + board.writes, board.reads, board.writes, settings_used);
        $display("%0d were out of range and %0d chunks were filled on first write.",
                 board.oor_hits, board.chunks_filled);
        if (board.fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", board.fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1ms;
        $display("Timeout with %0d results outstanding", board.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/ctms_pkg.sv
rtl/ctms_fifo.sv
rtl/ctms_front.sv
rtl/ctms_back.sv
rtl/chunked_tile_map_store_top.sv
rtl/ctms_checker.sv
tb/sv/chunked_tile_map_store_top_test.sv
